FILE: rtl/asa_pkg.sv
package asa_pkg;

  // Store geometry and field widths
  localparam int STORE_DEPTH = 8;
  localparam int ADDR_W      = 3;
  localparam int VALUE_W     = 10;
  localparam int SUM_W       = 16;
  localparam int COUNT_W     = 7;
  localparam int MUX_W       = 4;
  localparam int ACTIVE_W    = 4;
  localparam int TABLE_W     = 32;

  // Parameter defaults
  localparam int SAMPLES_LOG2_DEFAULT = 4;
  localparam int CHANNELS_DEFAULT     = 8;

  // Request kinds carried on tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Register select (paddr bit 2)
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_MUX    = 1'b1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd1;

  // Write request from the scan control to the average store
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } store_wr_t;

  // Per-request status from the scan control
  typedef struct packed {
    logic             stored;
    logic [MUX_W-1:0] mux_select;
  } scan_status_t;

endpackage

FILE: rtl/asa_store.sv
module asa_store (
  input  logic                          clk,
  input  logic                          rst,
  input  asa_pkg::store_wr_t            wr,
  input  logic                          rd_en,
  input  logic [asa_pkg::ADDR_W-1:0]    rd_addr,
  output logic [asa_pkg::VALUE_W-1:0]   rd_value
);

  logic [asa_pkg::VALUE_W-1:0] mem [asa_pkg::STORE_DEPTH];
  logic [asa_pkg::STORE_DEPTH-1:0] valid;
  logic [asa_pkg::VALUE_W-1:0] rd_data;
  logic rd_hit;

  // Write the average array
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Register the read data; hold it until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (rd_en) begin
      rd_hit <= valid[rd_addr];
    end
  end

  assign rd_value = rd_hit ? rd_data : '0;

endmodule

FILE: rtl/asa_ctrl.sv
module asa_ctrl #(
  parameter int SAMPLES_LOG2 = asa_pkg::SAMPLES_LOG2_DEFAULT,
  parameter int CHANNELS     = asa_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          operation,
  input  logic [asa_pkg::VALUE_W-1:0]   sample,
  input  logic [asa_pkg::ACTIVE_W-1:0]  active_channels,
  input  logic [asa_pkg::TABLE_W-1:0]   mux_code_table,
  output asa_pkg::store_wr_t            wr,
  output asa_pkg::scan_status_t         status
);

  localparam int LIMIT = (CHANNELS < asa_pkg::STORE_DEPTH) ? CHANNELS : asa_pkg::STORE_DEPTH;
  localparam logic [asa_pkg::ACTIVE_W-1:0] LIMIT_N = asa_pkg::ACTIVE_W'(LIMIT);
  localparam logic [asa_pkg::COUNT_W-1:0] TARGET = asa_pkg::COUNT_W'(1 << SAMPLES_LOG2);

  logic [asa_pkg::SUM_W-1:0]   running_sum, running_sum_next;
  logic [asa_pkg::COUNT_W-1:0] sample_count, sample_count_next;
  logic [asa_pkg::ADDR_W-1:0]  scan_position, scan_position_next;
  logic [asa_pkg::ACTIVE_W-1:0] eff_n;
  logic [asa_pkg::ACTIVE_W-1:0] pos_inc;
  logic [asa_pkg::SUM_W-1:0]   sum_shift;
  logic                        do_store;

  // Saturate the channel count into 1..LIMIT
  always_comb begin
    if (active_channels == '0) begin
      eff_n = asa_pkg::ACTIVE_W'(1);
    end else if (active_channels > LIMIT_N) begin
      eff_n = LIMIT_N;
    end else begin
      eff_n = active_channels;
    end
  end

  assign pos_inc   = {1'b0, scan_position} + asa_pkg::ACTIVE_W'(1);
  assign sum_shift = running_sum >> SAMPLES_LOG2;
  assign do_store  = accept && (operation == asa_pkg::OP_SAMPLE) && (sample_count >= TARGET);

  // Accumulate, or store the average and advance the scan
  always_comb begin
    running_sum_next   = running_sum;
    sample_count_next  = sample_count;
    scan_position_next = scan_position;
    if (accept && (operation == asa_pkg::OP_SAMPLE)) begin
      if (do_store) begin
        running_sum_next   = '0;
        sample_count_next  = '0;
        scan_position_next = (pos_inc >= eff_n) ? '0 : pos_inc[asa_pkg::ADDR_W-1:0];
      end else begin
        running_sum_next  = running_sum + asa_pkg::SUM_W'(sample);
        sample_count_next = sample_count + asa_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      sample_count  <= '0;
      scan_position <= '0;
    end else begin
      running_sum   <= running_sum_next;
      sample_count  <= sample_count_next;
      scan_position <= scan_position_next;
    end
  end

  assign wr.we   = do_store;
  assign wr.addr = scan_position;
  assign wr.data = sum_shift[asa_pkg::VALUE_W-1:0];

  assign status.stored     = do_store;
  assign status.mux_select = mux_code_table[scan_position_next * asa_pkg::MUX_W +: asa_pkg::MUX_W];

endmodule

FILE: rtl/adc_scan_averager.sv
// Converter scan averager: sums 2^SAMPLES_LOG2 samples per channel, stores the average.
// An accepted request's result appears on the master side in the next cycle.
// Throughput: one request per cycle while the result side is not stalled; the average store's single registered read
// port serves one read request each cycle and writes land at the accepting edge.
// Reset (rst, synchronous) clears the scan state, valid bits and configuration registers at once;
// no clearing pass is needed, so requests are taken from the first cycle after reset.
module adc_scan_averager #(
  parameter int SAMPLES_LOG2 = asa_pkg::SAMPLES_LOG2_DEFAULT,
  parameter int CHANNELS     = asa_pkg::CHANNELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] sample, [12:10] read_channel, [15:13] zero
  input  logic        s_tuser,   // [0] operation
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] read_value, [13:10] mux_select, [15:14] zero
  output logic        m_tuser,   // [0] average_stored
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [asa_pkg::ACTIVE_W-1:0] active_channels;
  logic [asa_pkg::TABLE_W-1:0]  mux_code_table;
  logic                         s_accept;
  logic                         cfg_write;
  asa_pkg::store_wr_t           wr;
  asa_pkg::scan_status_t        status;
  logic [asa_pkg::VALUE_W-1:0]  rd_value;

  logic                         res_valid;
  logic                         res_op;
  logic                         res_stored;
  logic [asa_pkg::MUX_W-1:0]    res_mux;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= asa_pkg::ACTIVE_RESET;
      mux_code_table  <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        asa_pkg::REG_ACTIVE: active_channels <= pwdata[asa_pkg::ACTIVE_W-1:0];
        asa_pkg::REG_MUX:    mux_code_table  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      asa_pkg::REG_ACTIVE: prdata = {28'd0, active_channels};
      asa_pkg::REG_MUX:    prdata = mux_code_table;
      default:             prdata = '0;
    endcase
  end

  // Take a request whenever the result slot is free or draining
  assign s_tready = !res_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  asa_ctrl #(
    .SAMPLES_LOG2 (SAMPLES_LOG2),
    .CHANNELS     (CHANNELS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .accept          (s_accept),
    .operation       (s_tuser),
    .sample          (s_tdata[9:0]),
    .active_channels (active_channels),
    .mux_code_table  (mux_code_table),
    .wr              (wr),
    .status          (status)
  );

  asa_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (s_accept),
    .rd_addr  (s_tdata[12:10]),
    .rd_value (rd_value)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s_accept) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res_op     <= s_tuser;
      res_stored <= status.stored;
      res_mux    <= status.mux_select;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tuser  = res_stored;
  assign m_tdata  = {2'b00, res_mux, (res_op == asa_pkg::OP_READ) ? rd_value : 10'd0};

  // A stored average comes from a sample request and reports no read value
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[9:0] == 10'd0))
    else $error("stored-average result carries a read value");

  // Every accepted request shows a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_accept |=> m_tvalid)
    else $error("accepted request produced no result");

  // Store writes only on sample requests
  assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (s_accept && (s_tuser == asa_pkg::OP_SAMPLE)))
    else $error("store write without a sample request");

  // Without a pending result the block takes requests
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request side stalled with empty result slot");

endmodule
